// ===== sv/mexp_pkg.sv =====
// Package for the modular exponentiation block.
// Holds the field width, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SET_BASE,
    ST_CHECK,
    ST_MUL,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic reduce;
    logic commit_base;
    logic start_mul;
    logic commit_bit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic exp_zero;
    logic mod_zero;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/mexp_lane.sv =====
// One modular multiply lane: shift-and-add product reduced every step.
// Takes the multiplier one bit per cycle while step_i is high, most significant bit first.
// Depends on nothing outside this file.
`default_nettype none

module mexp_lane #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             clear_i,
  input  wire logic             step_i,
  input  wire logic             bit_i,
  input  wire logic [WIDTH-1:0] mcand_i,
  input  wire logic [WIDTH-1:0] modulus_i,
  output logic      [WIDTH-1:0] prod_o
);

  logic [WIDTH-1:0] prod_q, prod_d;
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod_x1;
  logic [WIDTH+1:0] mod_x2;
  logic [WIDTH+1:0] red;

  // The sum 2*prod + bit*mcand stays below three moduli, so at most two
  // subtractions bring it back into range.
  always_comb begin
    mod_x1 = {2'b00, modulus_i};
    mod_x2 = {1'b0, modulus_i, 1'b0};
    sum    = {1'b0, prod_q, 1'b0} + (bit_i ? {2'b00, mcand_i} : '0);
    if (sum >= mod_x2) begin
      red = sum - mod_x2;
    end else if (sum >= mod_x1) begin
      red = sum - mod_x1;
    end else begin
      red = sum;
    end
    prod_d = red[WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      prod_q <= '0;
    end else if (step_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== sv/mexp_dp.sv =====
// Datapath of the modular exponentiation block: operand registers, bit
// counter, two multiply lanes (accumulate and square) and the result register.
// Depends on mexp_pkg and mexp_lane.
`default_nettype none

module mexp_dp #(
  parameter int WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mexp_pkg::cmd_t                cmd_i,
  output mexp_pkg::status_t                  status_o,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  base_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  exponent_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  modulus_i,
  output logic      [mexp_pkg::FIELD_W-1:0]  power_mod_o,
  output logic                               bad_modulus_o
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam int EXT_W = (WIDTH > mexp_pkg::FIELD_W) ? WIDTH : mexp_pkg::FIELD_W;
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  logic [EXT_W-1:0] base_ext, exp_ext, mod_ext, acc_ext;
  logic [WIDTH-1:0] base_w, exp_w, mod_w;

  logic [WIDTH-1:0] base_q, exp_q, mod_q, acc_q, mbits_q;
  logic [CNT_W-1:0] cnt_q;
  logic [mexp_pkg::FIELD_W-1:0] power_q;
  logic bad_q;

  logic [WIDTH-1:0] sq_mcand, sq_prod, acc_prod;
  logic lane_clear;

  // Operands are taken in their low WIDTH bits.
  assign base_ext = EXT_W'(base_i);
  assign exp_ext  = EXT_W'(exponent_i);
  assign mod_ext  = EXT_W'(modulus_i);
  assign base_w   = base_ext[WIDTH-1:0];
  assign exp_w    = exp_ext[WIDTH-1:0];
  assign mod_w    = mod_ext[WIDTH-1:0];
  assign acc_ext  = EXT_W'(acc_q);

  assign lane_clear = cmd_i.load | cmd_i.start_mul;

  // During the initial reduction the square lane computes 1 * base mod m.
  assign sq_mcand = cmd_i.reduce ? ONE : base_q;

  mexp_lane #(.WIDTH(WIDTH)) u_acc_lane (
    .clk_i     (clk_i),
    .clear_i   (lane_clear),
    .step_i    (cmd_i.step),
    .bit_i     (mbits_q[WIDTH-1]),
    .mcand_i   (acc_q),
    .modulus_i (mod_q),
    .prod_o    (acc_prod)
  );

  mexp_lane #(.WIDTH(WIDTH)) u_sq_lane (
    .clk_i     (clk_i),
    .clear_i   (lane_clear),
    .step_i    (cmd_i.step),
    .bit_i     (mbits_q[WIDTH-1]),
    .mcand_i   (sq_mcand),
    .modulus_i (mod_q),
    .prod_o    (sq_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (lane_clear) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mbits_q <= base_w;
    end else if (cmd_i.start_mul) begin
      mbits_q <= base_q;
    end else if (cmd_i.step) begin
      mbits_q <= {mbits_q[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mod_q <= mod_w;
      exp_q <= exp_w;
      acc_q <= ONE;
    end else if (cmd_i.commit_bit) begin
      if (exp_q[0]) begin
        acc_q <= acc_prod;
      end
      exp_q <= exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_base || cmd_i.commit_bit) begin
      base_q <= sq_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      bad_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      power_q <= status_o.mod_zero ? '0 : acc_ext[mexp_pkg::FIELD_W-1:0];
      bad_q   <= status_o.mod_zero;
    end
  end

  assign status_o.cnt_last = (cnt_q == CNT_W'(WIDTH - 1));
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.mod_zero = (mod_q == '0);

  assign power_mod_o   = power_q;
  assign bad_modulus_o = bad_q;

`ifndef SYNTHESIS
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q |-> (power_q == '0))
    else $error("bad modulus result is not zero");

  // With a modulus of one the accumulator keeps its start value until a set bit.
  a_acc_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_bit && (mod_q > ONE)) |=> (acc_q < mod_q))
    else $error("accumulator not reduced below modulus");

  a_bad_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (bad_q == $past(status_o.mod_zero)))
    else $error("bad modulus flag does not follow the modulus");
`endif

endmodule

`default_nettype wire

// ===== sv/mexp_ctrl.sv =====
// Controller of the modular exponentiation block: state machine that
// sequences reduction, per-bit multiplies and the output transfer.
// Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire mexp_pkg::status_t status_i,
  output mexp_pkg::cmd_t         cmd_o
);

  mexp_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        cmd_o.step   = 1'b1;
        cmd_o.reduce = 1'b1;
        if (status_i.cnt_last) begin
          state_d = mexp_pkg::ST_SET_BASE;
        end
      end
      mexp_pkg::ST_SET_BASE: begin
        cmd_o.commit_base = 1'b1;
        state_d           = mexp_pkg::ST_CHECK;
      end
      mexp_pkg::ST_CHECK: begin
        if (status_i.mod_zero || status_i.exp_zero) begin
          state_d = mexp_pkg::ST_DONE;
        end else begin
          cmd_o.start_mul = 1'b1;
          state_d         = mexp_pkg::ST_MUL;
        end
      end
      mexp_pkg::ST_MUL: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_last) begin
          state_d = mexp_pkg::ST_UPDATE;
        end
      end
      mexp_pkg::ST_UPDATE: begin
        cmd_o.commit_bit = 1'b1;
        state_d          = mexp_pkg::ST_CHECK;
      end
      mexp_pkg::ST_DONE: begin
        // Wait until the result register is free or is being drained.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != mexp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == mexp_pkg::ST_REDUCE))
    else $error("accepted transfer did not start the reduction");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while still stalled");

  a_mul_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::ST_MUL && status_i.cnt_last) |=>
      (state_q == mexp_pkg::ST_UPDATE))
    else $error("multiply did not end after the last bit");
`endif

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation, right-to-left binary scan, one item at a time.
// An item is taken on an input transfer, the base is reduced, then one multiply pass runs
// per exponent bit until the exponent is shifted to zero (none for a zero exponent or modulus).
// A new input is not taken while an item is in progress: the next input is taken at best
// the cycle after the result is loaded.
// Reset clears the controller and the output valid; operand registers are not reset.
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  base_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  exponent_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  modulus_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mexp_pkg::FIELD_W-1:0]  power_mod_o,
  output logic                               bad_modulus_o
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .base_i        (base_i),
    .exponent_i    (exponent_i),
    .modulus_i     (modulus_i),
    .power_mod_o   (power_mod_o),
    .bad_modulus_o (bad_modulus_o)
  );

endmodule

`default_nettype wire

// ===== tb/modular_exponentiation_tb.sv =====
// Self-checking testbench for the modular exponentiation block.
// Uses mexp_pkg for the field width; the expected power is computed here with 64-bit products.
// Directed corner items run first, then 500 random items, under random input gaps and output stalls.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

  localparam int W = mexp_pkg::FIELD_W;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_ITEMS = 60;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 1200;
  localparam longint LIMIT_CYCLES = 4000000;

  typedef struct {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    bit           drain;
  } modexp_req_t;

  typedef struct {
    logic [W-1:0] power_mod;
    logic         bad_modulus;
  } power_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] base_i = '0;
  logic [W-1:0] exponent_i = '0;
  logic [W-1:0] modulus_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] power_mod_o;
  logic         bad_modulus_o;

  modexp_req_t   pending_ops[$];
  power_result_t expected_powers[$];
  power_result_t want;

  longint cycle_cnt = 0;
  int     n_items = 0;
  int     sent_cnt = 0;
  int     results_cnt = 0;
  int     mismatch_cnt = 0;
  int     zero_mod_cnt = 0;
  int     zero_exp_cnt = 0;
  int     send_gap = 0;
  int     stall_left = 0;
  bit     in_fire = 1'b0;
  bit     send_free;
  bit     hold_done = 1'b0;

  modular_exponentiation #(
    .WIDTH(W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .base_i       (base_i),
    .exponent_i   (exponent_i),
    .modulus_i    (modulus_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .power_mod_o  (power_mod_o),
    .bad_modulus_o(bad_modulus_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Right-to-left square and multiply; operands stay below 2^32, so products fit in 64 bits.
  function automatic power_result_t modexp_predict(logic [W-1:0] b, logic [W-1:0] e,
                                                   logic [W-1:0] m);
    power_result_t r;
    logic [63:0]   acc;
    logic [63:0]   run;
    logic [W-1:0]  rest;
    r.bad_modulus = 1'b0;
    if (m == '0) begin
      r.power_mod = '0;
      r.bad_modulus = 1'b1;
      return r;
    end
    acc = 64'd1;
    run = 64'(b) % 64'(m);
    rest = e;
    while (rest != '0) begin
      if (rest[0]) begin
        acc = (acc * run) % 64'(m);
      end
      rest = rest >> 1;
      run = (run * run) % 64'(m);
    end
    r.power_mod = acc[W-1:0];
    return r;
  endfunction

  function automatic bit in_tail();
    return sent_cnt + TAIL_ITEMS >= n_items;
  endfunction

  task automatic add_req(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
    modexp_req_t req;
    req.base = b;
    req.exponent = e;
    req.modulus = m;
    req.drain = 1'b0;
    pending_ops.push_back(req);
  endtask

  task automatic note_mismatch(string what, power_result_t exp_r);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch at cycle %0d (%s): expected power_mod=%h bad_modulus=%b, got %h %b",
               cycle_cnt, what, exp_r.power_mod, exp_r.bad_modulus, power_mod_o, bad_modulus_o);
    end
  endtask

  // Monitor: records input transfers and checks result transfers.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_powers.push_back(modexp_predict(base_i, exponent_i, modulus_i));
        in_fire = 1'b1;
        if (modulus_i == '0) zero_mod_cnt++;
        if (exponent_i == '0) zero_exp_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_cnt++;
        if (expected_powers.size() == 0) begin
          want.power_mod = 'x;
          want.bad_modulus = 1'bx;
          note_mismatch("no result expected", want);
        end else begin
          want = expected_powers.pop_front();
          if (power_mod_o !== want.power_mod || bad_modulus_o !== want.bad_modulus) begin
            note_mismatch("wrong field", want);
          end
        end
      end
    end
  end

  // Driver: the payload only changes after a transfer, and valid is not dropped while stalled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      send_free = !in_valid_i || in_fire;
      if (in_fire) begin
        in_fire = 1'b0;
        void'(pending_ops.pop_front());
        sent_cnt++;
        if (!in_tail() && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 19);
        end
      end
      if (send_free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && expected_powers.size() != 0)) begin
          base_i     <= pending_ops[0].base;
          exponent_i <= pending_ops[0].exponent;
          modulus_i  <= pending_ops[0].modulus;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off that backs up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_cnt >= 120) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!in_tail() && $urandom_range(0, 24) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_powers.size() + pending_ops.size());
    $display("modular_exponentiation_tb NOT OK");
    $finish;
  end

  initial begin
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    int           sel;

    // Corner cases: zero and one moduli, zero exponent, all-ones operands, base above modulus.
    add_req('0, '0, '0);
    add_req('1, '1, '0);
    add_req(32'd12345, '0, 32'd1);
    add_req('0, '0, 32'd97);
    add_req(32'd7, 32'd5, 32'd1);
    add_req('1, '1, 32'd1);
    add_req('0, 32'd1, 32'd13);
    add_req('1, 32'd1, '1);
    add_req('1, '1, '1);
    add_req(32'hFFFF_FFFE, '1, '1);
    add_req(32'd2, 32'd10, 32'd1000);
    add_req(32'd3, 32'd200, 32'd2);
    add_req(32'd97, 32'd3, 32'd97);
    add_req('1, 32'd2, 32'hFFFF_FFFB);
    add_req(32'hDEAD_BEEF, '1, 32'hFFFF_FFFB);
    add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    add_req(32'd5, 32'h0000_0001, 32'd3);
    add_req(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
    add_req(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAB);
    add_req(32'd2, 32'd31, 32'hFFFF_FFFF);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 19);
      b = $urandom;
      e = $urandom;
      m = $urandom;
      case (sel) inside
        0: m = '0;
        1: e = '0;
        2, 3: m = $urandom_range(1, 16);
        4: e = $urandom_range(0, 255);
        5: m = {1'b1, m[W-2:0]};
        6: b = '1;
        default: ;
      endcase
      add_req(b, e, m);
      // The sender holds these until every earlier result has arrived.
      if (k == 0 || k == 250) pending_ops[$].drain = 1'b1;
    end
    n_items = pending_ops.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || expected_powers.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d mismatches in %0d cycles",
             sent_cnt, results_cnt, mismatch_cnt, cycle_cnt);
    $display("covered %0d zero moduli and %0d zero exponents, with a long output hold-off",
             zero_mod_cnt, zero_exp_cnt);
    if (mismatch_cnt == 0 && expected_powers.size() == 0) begin
      $display("modular_exponentiation_tb OK");
    end else begin
      $display("modular_exponentiation_tb NOT OK");
    end
    $finish;
  end

endmodule
